// ===== rtl/sssc_pkg.sv =====
// Shared types, codes and constants for the servo slew and settle controller.
// No dependencies; every other file in rtl/ imports this package.
package sssc_pkg;

    // Angle fixed point: fraction bits of the 1/256 degree unit
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int ANGLE_W         = 16;
    localparam int TIME_W          = 32;
    localparam int RAMP_W          = 24;
    localparam int PROD_W          = RAMP_W + TIME_W;

    // Rounding half of one whole degree
    localparam int HALF_ANGLE = (ANGLE_FRAC_BITS > 0) ? (1 << (ANGLE_FRAC_BITS - 1)) : 0;

    // Step saturation: ramp * dt at or above this gives a step of at least 65535
    localparam int          STEP_X_W      = 26;
    localparam logic [25:0] STEP_SAT_LIM  = 26'd65536000;
    // floor(x / 1000) = (x * RECIP_1000) >> RECIP_SHIFT, exact for x < 2^26
    localparam int          RECIP_W       = 27;
    localparam logic [26:0] RECIP_1000    = 27'd68719477;
    localparam int          RECIP_SHIFT   = 36;

    // Operation codes
    localparam logic [2:0] OP_BEGIN  = 3'd0;
    localparam logic [2:0] OP_SET    = 3'd1;
    localparam logic [2:0] OP_TICK   = 3'd2;
    localparam logic [2:0] OP_ATTACH = 3'd3;
    localparam logic [2:0] OP_DETACH = 3'd4;

    // Configuration register indexes
    localparam int         CFG_IDX_W       = 3;
    localparam int         CFG_DATA_W      = 32;
    localparam logic [2:0] REG_MIN_ANGLE   = 3'd0;
    localparam logic [2:0] REG_MAX_ANGLE   = 3'd1;
    localparam logic [2:0] REG_RAMP_RATE   = 3'd2;
    localparam logic [2:0] REG_DEADBAND    = 3'd3;
    localparam logic [2:0] REG_SETTLE_TIME = 3'd4;
    localparam logic [2:0] REG_AUTO_DETACH = 3'd5;
    localparam logic [2:0] REG_CLOSED      = 3'd6;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] angle;
        logic [31:0] time_ms;
    } t_in_word;

    typedef struct packed {
        logic        write_strobe;
        logic [7:0]  servo_degrees;
        logic [15:0] position;
        logic        attached;
        logic        on_target;
    } t_out_word;

    typedef struct packed {
        logic [15:0] min_angle;
        logic [15:0] max_angle;
        logic [23:0] ramp_rate;
        logic [15:0] deadband;
        logic [31:0] settle_time_ms;
        logic        auto_detach_enable;
        logic [15:0] closed_angle;
    } t_cfg;

    // Low limit is tested first: with crossed limits, values below lo still give lo
    function automatic logic [15:0] clamp_angle(input logic [15:0] a,
                                                input logic [15:0] lo,
                                                input logic [15:0] hi);
        if (a < lo) return lo;
        if (a > hi) return hi;
        return a;
    endfunction

    function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

// ===== rtl/sssc_cfg_regs.sv =====
// Configuration register file of the servo slew and settle controller.
// Depends on sssc_pkg for register indexes and the t_cfg struct.
module sssc_cfg_regs
    import sssc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Write one register per enabled cycle; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_angle          <= 16'd0;
            r_cfg.max_angle          <= 16'd46080;
            r_cfg.ramp_rate          <= 24'd0;
            r_cfg.deadband           <= 16'd256;
            r_cfg.settle_time_ms     <= 32'd500;
            r_cfg.auto_detach_enable <= 1'b0;
            r_cfg.closed_angle       <= 16'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MIN_ANGLE:   r_cfg.min_angle          <= i_cfg_data[15:0];
                REG_MAX_ANGLE:   r_cfg.max_angle          <= i_cfg_data[15:0];
                REG_RAMP_RATE:   r_cfg.ramp_rate          <= i_cfg_data[23:0];
                REG_DEADBAND:    r_cfg.deadband           <= i_cfg_data[15:0];
                REG_SETTLE_TIME: r_cfg.settle_time_ms     <= i_cfg_data;
                REG_AUTO_DETACH: r_cfg.auto_detach_enable <= i_cfg_data[0];
                REG_CLOSED:      r_cfg.closed_angle       <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/sssc_engine.sv =====
// Servo state and single-pass update for one operation word.
// Depends on sssc_pkg for codes, clamp and distance helpers, and word types.
module sssc_engine
    import sssc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_ramp_load,
    input  logic [RAMP_W-1:0] i_ramp_value,
    input  logic              i_step,
    input  t_in_word          i_item,
    input  logic [PROD_W-1:0] i_pn,
    output t_out_word         o_res
);

    // Servo state; r_pl tracks ramp_rate * r_last so dt * ramp is a subtraction
    logic [15:0]       r_cur, r_tgt;
    logic [31:0]       r_last, r_since;
    logic [PROD_W-1:0] r_pl;
    logic              r_atf, r_att;

    logic [15:0]       n_cur, n_tgt;
    logic [31:0]       n_last, n_since;
    logic [PROD_W-1:0] n_pl;
    logic              n_atf, n_att, strobe;

    logic [15:0]       nt, cur_c, closed_c, span, step, step_q, moved, moved_c;
    logic              dt_zero, wrap, sat, ramp_zero;
    logic [PROD_W-1:0] p;
    logic [STEP_X_W-1:0] x;
    logic [STEP_X_W+RECIP_W-1:0] prod;
    logic              in_still, in_moved, detach;
    logic [31:0]       since_still, since_moved, settled_for;
    logic [15:0]       out_c;
    logic [16:0]       cmd_sum, cmd_whole;

    assign nt        = clamp_angle(i_item.angle, i_cfg.min_angle, i_cfg.max_angle);
    assign cur_c     = clamp_angle(r_cur, i_cfg.min_angle, i_cfg.max_angle);
    assign closed_c  = clamp_angle(i_cfg.closed_angle, i_cfg.min_angle, i_cfg.max_angle);
    assign ramp_zero = (i_cfg.ramp_rate == '0);
    assign dt_zero   = (i_item.time_ms == r_last);
    assign wrap      = (i_item.time_ms < r_last);

    // Ramp times elapsed ms, with the time wrap folded back in
    assign p = i_pn - r_pl + (wrap ? {i_cfg.ramp_rate, 32'h0} : {PROD_W{1'b0}});

    // Step = p / 1000, saturated at 65535
    assign sat    = (p[PROD_W-1:STEP_X_W] != '0) || (p[STEP_X_W-1:0] >= STEP_SAT_LIM);
    assign x      = p[STEP_X_W-1:0];
    assign prod   = {{RECIP_W{1'b0}}, x} * {{STEP_X_W{1'b0}}, RECIP_1000};
    assign step_q = prod[RECIP_SHIFT+15:RECIP_SHIFT];
    assign step   = sat ? 16'hFFFF : step_q;

    // Move toward target, never past it
    assign span    = abs_diff(r_tgt, r_cur);
    assign moved   = (step >= span) ? r_tgt :
                     (r_tgt > r_cur) ? (r_cur + step) : (r_cur - step);
    assign moved_c = clamp_angle(moved, i_cfg.min_angle, i_cfg.max_angle);

    // At-target tracking for the unmoved and the moved position
    assign in_still    = (span <= i_cfg.deadband);
    assign since_still = in_still ? (r_atf ? r_since : i_item.time_ms) : 32'h0;
    assign in_moved    = (abs_diff(r_tgt, moved_c) <= i_cfg.deadband);
    assign since_moved = in_moved ? (r_atf ? r_since : i_item.time_ms) : 32'h0;
    assign settled_for = i_item.time_ms - since_moved;

    // Auto detach once settled at the closed angle
    assign detach = i_cfg.auto_detach_enable
                 && (abs_diff(r_tgt, closed_c) <= i_cfg.deadband)
                 && in_moved && (since_moved != 32'h0)
                 && (settled_for >= i_cfg.settle_time_ms);

    // Next state for one operation
    always_comb begin
        n_cur   = r_cur;
        n_tgt   = r_tgt;
        n_last  = r_last;
        n_since = r_since;
        n_pl    = r_pl;
        n_atf   = r_atf;
        n_att   = r_att;
        strobe  = 1'b0;
        unique case (i_item.op)
            OP_BEGIN: begin
                n_att   = 1'b1;
                n_cur   = nt;
                n_tgt   = nt;
                n_last  = i_item.time_ms;
                n_pl    = i_pn;
                strobe  = 1'b1;
                n_since = i_item.time_ms;
                n_atf   = 1'b1;
            end
            OP_SET: begin
                if (nt != r_tgt) begin
                    n_tgt = nt;
                    if (!r_att) begin
                        n_att  = 1'b1;
                        n_cur  = cur_c;
                        strobe = 1'b1;
                        n_last = i_item.time_ms;
                        n_pl   = i_pn;
                    end
                    n_since = 32'h0;
                    n_atf   = 1'b0;
                    if (ramp_zero) begin
                        n_cur   = nt;
                        strobe  = 1'b1;
                        n_last  = i_item.time_ms;
                        n_pl    = i_pn;
                        n_since = i_item.time_ms;
                        n_atf   = 1'b1;
                    end
                end
            end
            OP_TICK: begin
                if (r_att) begin
                    n_last = i_item.time_ms;
                    n_pl   = i_pn;
                    if (!dt_zero) begin
                        if (ramp_zero) begin
                            n_atf   = in_still;
                            n_since = since_still;
                        end else begin
                            n_cur   = moved_c;
                            strobe  = 1'b1;
                            n_atf   = in_moved;
                            n_since = since_moved;
                            if (detach) begin
                                n_att = 1'b0;
                            end
                        end
                    end
                end
            end
            OP_ATTACH: begin
                if (!r_att) begin
                    n_att  = 1'b1;
                    n_cur  = cur_c;
                    strobe = 1'b1;
                    n_last = i_item.time_ms;
                    n_pl   = i_pn;
                end
            end
            OP_DETACH: begin
                n_att = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Commit state on a step; otherwise a ramp rewrite rescales the stored product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= 16'h0;
            r_tgt   <= 16'h0;
            r_last  <= 32'h0;
            r_since <= 32'h0;
            r_pl    <= {PROD_W{1'b0}};
            r_atf   <= 1'b0;
            r_att   <= 1'b0;
        end else if (i_step) begin
            r_cur   <= n_cur;
            r_tgt   <= n_tgt;
            r_last  <= n_last;
            r_since <= n_since;
            r_pl    <= n_pl;
            r_atf   <= n_atf;
            r_att   <= n_att;
        end else if (i_ramp_load) begin
            r_pl <= {{TIME_W{1'b0}}, i_ramp_value} * {{RAMP_W{1'b0}}, r_last};
        end
    end

    // Whole-degree command from the clamped new position
    assign out_c     = clamp_angle(n_cur, i_cfg.min_angle, i_cfg.max_angle);
    assign cmd_sum   = {1'b0, out_c} + 17'(HALF_ANGLE);
    assign cmd_whole = cmd_sum >> ANGLE_FRAC_BITS;

    assign o_res.write_strobe  = strobe;
    assign o_res.servo_degrees = (cmd_whole > 17'd255) ? 8'hFF : cmd_whole[7:0];
    assign o_res.position      = n_cur;
    assign o_res.attached      = n_att;
    assign o_res.on_target     = n_atf;

endmodule

// ===== rtl/servo_slew_settle_controller.sv =====
// Channel   | Signals                          | Word
// ----------+----------------------------------+---------------------------------
// input     | i_in_valid, o_in_ready, i_in     | t_in_word: op, angle, time_ms
// output    | o_out_valid, i_out_ready, o_out  | t_out_word: strobe, degrees, ...
// config    | i_cfg_we, i_cfg_index, i_cfg_data| one register per write
//
// One word per cycle while the output is not stalled; an input word is registered in r_in, then its result in r_out.
// Stage one registers the word and ramp * time_ms; stage two updates the servo
// state and registers the result word.
// Reset (i_rst_n low, synchronous) empties both stages and loads default registers.
// A stalled output holds its word; the input stage still fills behind it.
// Depends on sssc_pkg, sssc_cfg_regs and sssc_engine.
module servo_slew_settle_controller
    import sssc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg              cfg;
    t_in_word          r_in;
    t_out_word         r_out, res;
    logic [PROD_W-1:0] r_pn;
    logic              r_in_valid, r_out_valid;
    logic              accept, advance, ramp_load;

    sssc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign ramp_load = i_cfg_we && (i_cfg_index == REG_RAMP_RATE);

    // Handshake: advance when the result register is free or being drained
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the word and its ramp product, and register the result word on advance
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in;
            r_pn <= {{TIME_W{1'b0}}, cfg.ramp_rate} * {{RAMP_W{1'b0}}, i_in.time_ms};
        end
        if (advance) begin
            r_out <= res;
        end
    end

    sssc_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_ramp_load  (ramp_load),
        .i_ramp_value (i_cfg_data[RAMP_W-1:0]),
        .i_step       (advance),
        .i_item       (r_in),
        .i_pn         (r_pn),
        .o_res        (res)
    );

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== rtl/sssc_checker.sv =====
// Port-level checks for the servo slew and settle controller, bound to the top.
// Depends on sssc_pkg and servo_slew_settle_controller.
module sssc_checker
    import sssc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input t_in_word              i_in,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input t_out_word             o_out,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("output word changed while stalled");

    // Input stalls only behind a stalled output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without output back-pressure");

    // A fresh result follows an earlier accepted word
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2))
        else $error("result appeared without an accepted word");

    // Reset drops any pending result
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind servo_slew_settle_controller sssc_checker u_sssc_checker (.*);

// ===== tb/tb_servo_slew_settle_controller.sv =====
// Self-checking bench for servo_slew_settle_controller: a word-level model of the
// slew ramp and settle timer predicts every output word from the accepted commands.
// Depends on sssc_pkg and the RTL under rtl/.
`timescale 1ns / 100ps

module tb_servo_slew_settle_controller
    import sssc_pkg::*;
();

    localparam int PHASES         = 8;
    localparam int PHASE_WORDS    = 195;
    localparam int MAX_GAP        = 60;
    localparam int WATCHDOG_LIMIT = 4000;

    // Sender and receiver idling patterns
    localparam int IDLE_NONE     = 0;
    localparam int IDLE_SENDER   = 1;
    localparam int IDLE_RECEIVER = 2;
    localparam int IDLE_BOTH     = 3;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_word              i_in        = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_word             o_out;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    int        idle_mode = IDLE_NONE;
    bit [31:0] tnow      = '0;

    // Ramp model: own copy of registers and servo state, plus the words still due
    class servo_ramp_checker;
        bit [15:0] lim_lo, lim_hi, band, closed_set;
        bit [23:0] slew;
        bit [31:0] settle;
        bit        auto_off;

        bit [15:0] pos, tgt;
        bit [31:0] last_ms, since_ms;
        bit        near, drive_on, wrote;

        t_out_word servo_words_due[$];
        int        error_count;

        function new();
            lim_lo     = 16'd0;
            lim_hi     = 16'd46080;
            slew       = 24'd0;
            band       = 16'd256;
            settle     = 32'd500;
            auto_off   = 1'b0;
            closed_set = 16'd0;
            pos        = '0;
            tgt        = '0;
            last_ms    = '0;
            since_ms   = '0;
            near       = 1'b0;
            drive_on   = 1'b0;
            error_count = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                REG_MIN_ANGLE:   lim_lo     = data[15:0];
                REG_MAX_ANGLE:   lim_hi     = data[15:0];
                REG_RAMP_RATE:   slew       = data[23:0];
                REG_DEADBAND:    band       = data[15:0];
                REG_SETTLE_TIME: settle     = data;
                REG_AUTO_DETACH: auto_off   = data[0];
                REG_CLOSED:      closed_set = data[15:0];
                default: ;
            endcase
        endfunction

        // Low limit wins when the limits are crossed
        function bit [15:0] limit(bit [15:0] a);
            if (a < lim_lo) return lim_lo;
            if (a > lim_hi) return lim_hi;
            return a;
        endfunction

        function bit [15:0] gap16(bit [15:0] a, bit [15:0] b);
            return (a > b) ? a - b : b - a;
        endfunction

        function bit [7:0] degrees();
            bit [16:0] d;
            d = ({1'b0, limit(pos)} + 17'(HALF_ANGLE)) >> ANGLE_FRAC_BITS;
            return (d > 17'd255) ? 8'd255 : d[7:0];
        endfunction

        // Keep the entry time while inside the deadband, clear it on leaving
        function void update_near(bit [31:0] now);
            if (gap16(tgt, pos) <= band) begin
                if (!near) since_ms = now;
                near = 1'b1;
            end else begin
                near     = 1'b0;
                since_ms = '0;
            end
        endfunction

        function void engage(bit [31:0] now);
            if (drive_on) return;
            drive_on = 1'b1;
            pos      = limit(pos);
            wrote    = 1'b1;
            last_ms  = now;
        endfunction

        // Advance the ramp by the elapsed time, then test for a settled close
        function void advance(bit [31:0] now);
            bit [31:0]       dt, held;
            bit [15:0]       closed_lim;
            longint unsigned step, cur;
            if (!drive_on) return;
            dt      = now - last_ms;
            last_ms = now;
            if (dt == 0) return;
            if (slew == 0) begin
                update_near(now);
                return;
            end
            step = (64'(slew) * 64'(dt)) / 64'd1000;
            if (step > 64'd65535) step = 64'd65535;
            cur = 64'(pos);
            if (tgt > pos)
                cur = (cur + step >= 64'(tgt)) ? 64'(tgt) : cur + step;
            else if (tgt < pos)
                cur = (cur <= 64'(tgt) + step) ? 64'(tgt) : cur - step;
            pos   = limit(cur[15:0]);
            wrote = 1'b1;
            update_near(now);
            if (auto_off) begin
                closed_lim = limit(closed_set);
                held       = now - since_ms;
                if (gap16(tgt, closed_lim) <= band && near && since_ms != 0 && held >= settle)
                    drive_on = 1'b0;
            end
        endfunction

        function void note_command(t_in_word w);
            bit [15:0] nt;
            t_out_word due;
            wrote = 1'b0;
            case (w.op)
                OP_BEGIN: begin
                    drive_on = 1'b1;
                    nt       = limit(w.angle);
                    pos      = nt;
                    tgt      = nt;
                    last_ms  = w.time_ms;
                    wrote    = 1'b1;
                    since_ms = w.time_ms;
                    update_near(w.time_ms);
                end
                OP_SET: begin
                    nt = limit(w.angle);
                    if (nt != tgt) begin
                        tgt = nt;
                        engage(w.time_ms);
                        since_ms = '0;
                        near     = 1'b0;
                        // Snap straight to the target when there is no ramp
                        if (slew == 0) begin
                            pos      = tgt;
                            wrote    = 1'b1;
                            last_ms  = w.time_ms;
                            since_ms = w.time_ms;
                            update_near(w.time_ms);
                        end
                    end
                end
                OP_TICK:   advance(w.time_ms);
                OP_ATTACH: engage(w.time_ms);
                OP_DETACH: drive_on = 1'b0;
                default: ;
            endcase
            due.write_strobe  = wrote;
            due.servo_degrees = degrees();
            due.position      = pos;
            due.attached      = drive_on;
            due.on_target     = near;
            servo_words_due.push_back(due);
        endfunction

        task report_mismatch(string what, longint unsigned got, longint unsigned want);
            $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
            error_count++;
        endtask

        task check_servo_word(t_out_word got);
            t_out_word want;
            if (servo_words_due.size() == 0) begin
                report_mismatch("output word with nothing due", got, 0);
                return;
            end
            want = servo_words_due.pop_front();
            if (got.write_strobe !== want.write_strobe)
                report_mismatch("write_strobe", got.write_strobe, want.write_strobe);
            if (got.servo_degrees !== want.servo_degrees)
                report_mismatch("servo_degrees", got.servo_degrees, want.servo_degrees);
            if (got.position !== want.position)
                report_mismatch("position", got.position, want.position);
            if (got.attached !== want.attached)
                report_mismatch("attached", got.attached, want.attached);
            if (got.on_target !== want.on_target)
                report_mismatch("on_target", got.on_target, want.on_target);
        endtask
    endclass

    servo_ramp_checker model;

    servo_slew_settle_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Sample both handshakes at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) model.note_command(i_in);
            if (o_out_valid && i_out_ready) model.check_servo_word(o_out);
        end
    end

    // Drive receiver back-pressure at the falling edge
    always @(negedge i_clk) begin
        case (idle_mode)
            IDLE_RECEIVER: i_out_ready <= ($urandom_range(0, 99) >= 83);
            IDLE_BOTH:     i_out_ready <= ($urandom_range(0, 99) >= 15);
            default:       i_out_ready <= 1'b1;
        endcase
    end

    // Stop the run if no word moves on either channel for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Offer one word, with a random gap ahead of it, and hold it until accepted
    task send_word(t_in_word w);
        int gap;
        int pct;
        gap = 0;
        pct = (idle_mode == IDLE_SENDER) ? 83 : (idle_mode == IDLE_BOTH) ? 15 : 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= w;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task send_op(logic [2:0] op, logic [15:0] angle, logic [31:0] time_ms);
        t_in_word w;
        w.op      = op;
        w.angle   = angle;
        w.time_ms = time_ms;
        send_word(w);
    endtask

    // Drop valid and wait until every due word has come out
    task drain();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (model.servo_words_due.size() != 0);
        repeat (3) @(negedge i_clk);
    endtask

    // Write enable stays high across back-to-back writes; the caller lowers it
    task write_reg(logic [2:0] idx, logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        model.set_reg(idx, data);
        @(negedge i_clk);
    endtask

    task apply_setting(int k);
        logic [15:0] lo, hi, band, closed;
        logic [23:0] ramp;
        logic [31:0] settle;
        logic        auto_en;
        case (k)
            0: begin
                lo = 0;     hi = 46080; ramp = 23040;    band = 256;
                settle = 300;           auto_en = 1'b1;  closed = 0;
            end
            1: begin
                lo = 1024;  hi = 40000; ramp = 5;        band = 0;
                settle = 0;             auto_en = 1'b1;  closed = 16'hFFFF;
            end
            2: begin
                lo = 0;     hi = 16'hFFFF; ramp = 24'hFFFFFF; band = 16'hFFFF;
                settle = 32'hFFFF_FFFF; auto_en = 1'b0;  closed = 0;
            end
            3: begin
                // crossed limits
                lo = 50000; hi = 10000; ramp = 100000;   band = 512;
                settle = 100;           auto_en = 1'b1;  closed = 30000;
            end
            4: begin
                lo = 0;     hi = 16'hFFFF; ramp = 0;     band = 128;
                settle = 50;            auto_en = 1'b1;  closed = 12800;
            end
            default: begin
                lo = $urandom_range(0, 1) ? 16'($urandom_range(0, 8000))
                                          : 16'($urandom_range(0, 65535));
                hi = $urandom_range(0, 1) ? 16'(65535 - $urandom_range(0, 20000))
                                          : 16'($urandom_range(0, 65535));
                ramp = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 50000));
                band = $urandom_range(0, 1) ? 16'($urandom_range(0, 1000))
                                            : 16'($urandom_range(0, 65535));
                settle  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1000);
                auto_en = 1'($urandom_range(0, 1));
                closed  = 16'($urandom_range(0, 65535));
            end
        endcase
        write_reg(REG_MIN_ANGLE, 32'(lo));
        write_reg(REG_MAX_ANGLE, 32'(hi));
        write_reg(REG_RAMP_RATE, 32'(ramp));
        write_reg(REG_DEADBAND, 32'(band));
        write_reg(REG_SETTLE_TIME, settle);
        write_reg(REG_AUTO_DETACH, 32'(auto_en));
        write_reg(REG_CLOSED, 32'(closed));
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Mostly ticks on a running clock, with targets often at the closed angle
    task make_word(output t_in_word w);
        int r;
        int r2;
        r         = $urandom_range(0, 99);
        w.angle   = 16'($urandom_range(0, 65535));
        if (r < 4) begin
            w.op = OP_BEGIN;
            if ($urandom_range(0, 3) == 0) tnow = $urandom;
        end else if (r < 20) begin
            w.op = OP_SET;
            if ($urandom_range(0, 2) == 0) w.angle = model.closed_set;
            tnow = tnow + $urandom_range(0, 20);
        end else if (r < 82) begin
            w.op = OP_TICK;
            r2   = $urandom_range(0, 99);
            if (r2 < 5)       tnow = tnow;
            else if (r2 < 75) tnow = tnow + $urandom_range(1, 60);
            else if (r2 < 95) tnow = tnow + $urandom_range(61, 3000);
            else              tnow = tnow + $urandom;
        end else if (r < 88) begin
            w.op = OP_ATTACH;
        end else if (r < 94) begin
            w.op = OP_DETACH;
        end else begin
            w.op = 3'($urandom_range(5, 7));
        end
        w.time_ms = (w.op > OP_DETACH) ? $urandom : tnow;
    endtask

    initial begin
        t_in_word w;
        model = new();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: detached tick, double attach, clamp and snap, same target
        send_op(OP_TICK, 16'h1234, 32'd10);
        send_op(OP_ATTACH, 16'h0000, 32'd20);
        send_op(OP_ATTACH, 16'hFFFF, 32'd30);
        send_op(OP_SET, 16'hFFFF, 32'd40);
        send_op(OP_SET, 16'hFFFF, 32'd50);
        send_op(OP_TICK, 16'h0000, 32'd60);
        send_op(OP_TICK, 16'h0000, 32'd60);
        send_op(OP_DETACH, 16'h0000, 32'd70);
        send_op(OP_DETACH, 16'h0000, 32'd80);
        // Entry at time zero reads as none
        send_op(OP_BEGIN, 16'h0000, 32'd0);
        send_op(3'd5, 16'hFFFF, 32'hFFFF_FFFF);
        send_op(3'd6, 16'hFFFF, 32'hFFFF_FFFF);
        send_op(3'd7, 16'h5555, 32'hAAAA_AAAA);

        // Directed: full range, saturated degrees and sub-unit steps
        drain();
        write_reg(REG_RAMP_RATE, 32'd1);
        write_reg(REG_MAX_ANGLE, 32'hFFFF);
        write_reg(REG_AUTO_DETACH, 32'd1);
        write_reg(REG_SETTLE_TIME, 32'd0);
        write_reg(REG_DEADBAND, 32'd0);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        send_op(OP_BEGIN, 16'hFFFF, 32'd100);
        send_op(OP_SET, 16'hFC00, 32'd100);
        send_op(OP_TICK, 16'h0000, 32'd200);
        send_op(OP_TICK, 16'h0000, 32'd2200);
        drain();
        write_reg(REG_RAMP_RATE, 32'h00FF_FFFF);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        send_op(OP_TICK, 16'h0000, 32'hFFFF_FF00);
        send_op(OP_SET, 16'h0000, 32'hFFFF_FF10);
        send_op(OP_TICK, 16'h0000, 32'h0000_0010);
        tnow = 32'h0000_0100;

        // Random phases, each with its own setting and idling pattern
        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            apply_setting(phase);
            idle_mode = phase % 4;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                // hold off until the pipeline is empty once per phase
                if (n == PHASE_WORDS / 2) drain();
                make_word(w);
                send_word(w);
            end
        end

        drain();
        repeat (8) @(negedge i_clk);
        if (model.error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
